/* design/ilid_pkg.sv */
// shared types and constants for the indexed list block
`default_nettype none

package ilid_pkg;

    localparam int unsigned MAX_OUT = 32;
    localparam int unsigned IDX_W   = 5;

    localparam logic [1:0] ACT_INS_FRONT = 2'd0;
    localparam logic [1:0] ACT_APPEND    = 2'd1;
    localparam logic [1:0] ACT_DELETE    = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] element;
        logic [IDX_W-1:0]   element_index;
        logic               list_empty;
        logic               insert_dropped;
        logic               last_of_run;
    } t_out_item;

    // tags that travel with an emit read until its data returns
    typedef struct packed {
        logic [IDX_W-1:0] element_index;
        logic             list_empty;
        logic             insert_dropped;
        logic             last_of_run;
    } t_emit_tag;

endpackage

`default_nettype wire

/* design/ilid_store.sv */
// list storage: one write port, one registered read port
`default_nettype none

module ilid_store #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [31:0]              i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [31:0]                   o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/ilid_outbuf.sv */
// two-entry result buffer: output register plus skid register
`default_nettype none

module ilid_outbuf import ilid_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_push_item,
    output logic           o_room,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    t_out_item  r_out;
    t_out_item  r_skid;
    logic       r_out_v;
    logic       r_skid_v;
    logic       pop;
    logic [1:0] occ_next;

    assign pop = r_out_v && !i_out_stall;

    // room for one more read issued now, counting the data arriving this cycle
    assign occ_next = 2'(r_out_v) + 2'(r_skid_v) + 2'(i_push) - 2'(pop);
    assign o_room   = (occ_next <= 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= i_push;
                if (i_push) begin
                    r_skid <= i_push_item;
                end
            end else begin
                r_out_v <= i_push;
                if (i_push) begin
                    r_out <= i_push_item;
                end
            end
        end else if (i_push) begin
            if (!r_out_v) begin
                r_out   <= i_push_item;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= i_push_item;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* design/indexed_list_insert_delete.sv */
// Ordered list of up to CAPACITY signed words with front insert, append and
// positional delete; the whole list is streamed out after every request.
// Input channel: i_in_valid / o_in_stall, payload i_in (action, value,
// position). Output channel: o_out_valid / i_out_stall, payload o_out.
// Each request produces one result per list entry, front to back, capped at
// MAX_OUT results, with last_of_run on the final one; an empty list gives a
// single result with list_empty set.
// Per request: an append or no-change request goes straight to the emit
// pass. An insert at the front into a list that is not full first moves every
// entry up by one, one memory read/write per cycle. A delete of a live
// position moves the entries behind it down by one. Results then leave at
// one per cycle while the receiver does not stall, paced by the single read
// port of the list memory.
// o_in_stall is high from acceptance until the last read of the emit pass is
// issued; the next request may be taken while results still wait in the
// two-entry output buffer. A stalled receiver holds o_out and pauses the
// emit reads. Reset empties the list; the memory itself is not cleared.
`default_nettype none

module indexed_list_insert_delete import ilid_pkg::*; #(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INS  = 2'd1;
    localparam logic [1:0] ST_DEL  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [AW-1:0]      r_waddr;
    logic               r_sh_pend;
    logic signed [31:0] r_value;
    logic               r_drop;
    logic               r_em_pend;
    t_emit_tag          r_em_tag;

    logic               in_acc;
    logic               full;
    logic               ins_req;
    logic               del_ok;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [31:0]        rd_data;
    logic               room;
    logic               em_issue;
    logic               em_empty;
    logic               em_last;
    logic               ins_done;
    logic               del_done;
    t_emit_tag          em_tag;
    t_out_item          push_item;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    assign full    = (r_count == CW'(CAPACITY));
    assign ins_req = (i_in.action == ACT_INS_FRONT) || (i_in.action == ACT_APPEND);
    assign del_ok  = (32'(i_in.position) < 32'(r_count));

    // emit pass bookkeeping
    assign em_empty = (r_count == '0);
    assign em_last  = em_empty || (32'(r_ptr) + 32'd1 == 32'(r_count))
                      || (32'(r_ptr) == MAX_OUT - 1);
    assign em_issue = (r_state == ST_EMIT) && room;

    always_comb begin
        em_tag.element_index  = IDX_W'(32'(r_ptr));
        em_tag.list_empty     = em_empty;
        em_tag.insert_dropped = r_drop;
        em_tag.last_of_run    = em_last;
    end

    assign ins_done = (r_state == ST_INS) && (r_ptr == '0) && !r_sh_pend;
    assign del_done = (r_state == ST_DEL) && (r_ptr >= r_count) && !r_sh_pend;

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(r_ptr);
        case (r_state)
            ST_INS: begin
                rd_en   = (r_ptr != '0);
                rd_addr = AW'(r_ptr - CW'(1));
            end
            ST_DEL: begin
                rd_en = (r_ptr < r_count);
            end
            ST_EMIT: begin
                rd_en = em_issue && !em_empty;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_waddr;
        wr_data = rd_data;
        if (r_sh_pend) begin
            wr_en = 1'b1;
        end else if (ins_done) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = r_value;
        end else if (in_acc && (i_in.action == ACT_APPEND) && !full) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_count);
            wr_data = i_in.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_sh_pend <= 1'b0;
            r_em_pend <= 1'b0;
            r_drop    <= 1'b0;
        end else begin
            r_sh_pend <= 1'b0;
            r_em_pend <= em_issue;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_drop  <= ins_req && full;
                        r_value <= i_in.value;
                        r_ptr   <= '0;
                        r_state <= ST_EMIT;
                        case (i_in.action)
                            ACT_INS_FRONT: begin
                                if (!full) begin
                                    r_ptr   <= r_count;
                                    r_state <= ST_INS;
                                end
                            end
                            ACT_APPEND: begin
                                if (!full) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_DELETE: begin
                                if (del_ok) begin
                                    r_ptr   <= CW'(i_in.position) + CW'(1);
                                    r_state <= ST_DEL;
                                end
                            end
                            default: begin
                                r_state <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_INS: begin
                    // move entries up from the back, one per cycle
                    if (rd_en) begin
                        r_waddr   <= AW'(r_ptr);
                        r_ptr     <= r_ptr - CW'(1);
                        r_sh_pend <= 1'b1;
                    end
                    if (ins_done) begin
                        r_count <= r_count + CW'(1);
                        r_ptr   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_DEL: begin
                    // pull entries behind the hole down by one
                    if (rd_en) begin
                        r_waddr   <= AW'(r_ptr - CW'(1));
                        r_ptr     <= r_ptr + CW'(1);
                        r_sh_pend <= 1'b1;
                    end
                    if (del_done) begin
                        r_count <= r_count - CW'(1);
                        r_ptr   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (em_issue) begin
                        r_em_tag <= em_tag;
                        r_ptr    <= r_ptr + CW'(1);
                        if (em_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        push_item.element        = r_em_tag.list_empty ? 32'sd0 : $signed(rd_data);
        push_item.element_index  = r_em_tag.element_index;
        push_item.list_empty     = r_em_tag.list_empty;
        push_item.insert_dropped = r_em_tag.insert_dropped;
        push_item.last_of_run    = r_em_tag.last_of_run;
    end

    ilid_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ilid_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_em_pend),
        .i_push_item (push_item),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* sim/ilid_tb_pkg.sv */
// scoreboard for the indexed list testbench: list predictor and result checks
package ilid_tb_pkg;

    import ilid_pkg::*;

    localparam int unsigned LIST_DEPTH  = 32;
    localparam int unsigned MAX_REPORTS = 10;

    class list_scoreboard;
        logic signed [31:0] entries [LIST_DEPTH];
        int unsigned        n_entries;
        t_out_item          pending [$];
        int unsigned        n_errors;

        function new();
            n_entries = 0;
            n_errors  = 0;
        endfunction

        // apply one accepted request to the predicted list, then queue the list dump
        function void note_request(t_in_item req);
            logic        dropped;
            int unsigned shown;
            int unsigned k;
            t_out_item   want;
            dropped = 1'b0;
            case (req.action)
                ACT_INS_FRONT, ACT_APPEND: begin
                    if (n_entries >= LIST_DEPTH) begin
                        dropped = 1'b1;
                    end else if (req.action == ACT_INS_FRONT) begin
                        for (k = n_entries; k > 0; k--)
                            entries[k] = entries[k-1];
                        entries[0] = req.value;
                        n_entries++;
                    end else begin
                        entries[n_entries] = req.value;
                        n_entries++;
                    end
                end
                ACT_DELETE: begin
                    if (32'(req.position) < n_entries) begin
                        for (k = 32'(req.position); k + 1 < n_entries; k++)
                            entries[k] = entries[k+1];
                        n_entries--;
                    end
                end
                default: ;
            endcase

            if (n_entries == 0) begin
                want.element        = '0;
                want.element_index  = '0;
                want.list_empty     = 1'b1;
                want.insert_dropped = dropped;
                want.last_of_run    = 1'b1;
                pending.push_back(want);
                return;
            end
            shown = (n_entries < MAX_OUT) ? n_entries : MAX_OUT;
            for (k = 0; k < shown; k++) begin
                want.element        = entries[k];
                want.element_index  = k[IDX_W-1:0];
                want.list_empty     = 1'b0;
                want.insert_dropped = dropped;
                want.last_of_run    = (k + 1 == shown);
                pending.push_back(want);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result: element %0d index %0d empty %0b dropped %0b last %0b",
                             got.element, got.element_index, got.list_empty,
                             got.insert_dropped, got.last_of_run);
                return;
            end
            want = pending.pop_front();
            if (got.element !== want.element || got.element_index !== want.element_index ||
                got.list_empty !== want.list_empty ||
                got.insert_dropped !== want.insert_dropped ||
                got.last_of_run !== want.last_of_run) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("mismatch: expected element %0d index %0d empty %0b dropped %0b last %0b",
                             want.element, want.element_index, want.list_empty,
                             want.insert_dropped, want.last_of_run);
                    $display("          got      element %0d index %0d empty %0b dropped %0b last %0b",
                             got.element, got.element_index, got.list_empty,
                             got.insert_dropped, got.last_of_run);
                end
            end
        endfunction
    endclass

endpackage

/* sim/tb_indexed_list_insert_delete.sv */
// testbench top for the indexed list block: stimulus, handshakes and end of run
module tb_indexed_list_insert_delete;

    import ilid_pkg::*;
    import ilid_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 350;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned HOLD_OFF_AFTER  = 150;
    localparam int unsigned DRAIN_CYCLES    = 120;
    localparam int unsigned IDLE_LIMIT      = 4000;

    typedef enum int unsigned {MODE_FILL, MODE_GROW, MODE_SHRINK, MODE_MIXED} t_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_bus    = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_bus;

    list_scoreboard sb;
    int unsigned    n_accepted = 0;
    int unsigned    idle_cycles = 0;

    // receiver state
    int unsigned hold_left    = 0;
    bit          held_off     = 1'b0;
    int unsigned stretch_left = 0;
    bit          choppy       = 1'b0;
    int unsigned stall_left   = 0;

    indexed_list_insert_delete #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_bus),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_bus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short pauses, now and then a long one
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item list_op(logic [1:0] act, logic signed [31:0] val,
                                         logic [7:0] pos);
        t_in_item req;
        req.action   = act;
        req.value    = val;
        req.position = pos;
        return req;
    endfunction

    function automatic t_in_item make_request(t_mode mode, int unsigned count);
        t_in_item    req;
        int unsigned roll;
        req.value    = pick_value();
        req.position = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                req.action = (roll < 50) ? ACT_INS_FRONT : ACT_APPEND;
            MODE_GROW:
                req.action = (roll < 42) ? ACT_INS_FRONT :
                             (roll < 84) ? ACT_APPEND :
                             (roll < 95) ? ACT_DELETE : ACT_NONE;
            MODE_SHRINK:
                req.action = (roll < 75) ? ACT_DELETE :
                             (roll < 87) ? ACT_INS_FRONT :
                             (roll < 97) ? ACT_APPEND : ACT_NONE;
            default:
                req.action = 2'($urandom_range(0, 3));
        endcase
        // deletes mostly hit a live entry; mixed mode keeps half of them wild
        if (req.action == ACT_DELETE && count != 0 && (mode != MODE_MIXED || roll[0]))
            req.position = 8'($urandom_range(0, count - 1));
        return req;
    endfunction

    task automatic send_request(input t_in_item req, input int unsigned pause);
        if (pause != 0) begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_bus   <= req;
        do @(posedge clk); while (in_stall);
        sb.note_request(req);
        n_accepted++;
    endtask

    initial begin
        int unsigned issued;
        int unsigned seg_len;
        t_mode       mode;
        bit          calm;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty list cases, extremes, front/back/middle deletes, out-of-range deletes
        send_request(list_op(ACT_NONE, 32'h1234_5678, 8'h00), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'h00), pick_pause());
        send_request(list_op(ACT_APPEND, 32'h7fff_ffff, 8'h00), pick_pause());
        send_request(list_op(ACT_INS_FRONT, 32'h8000_0000, 8'hff), pick_pause());
        send_request(list_op(ACT_APPEND, 32'h0000_0000, 8'h00), pick_pause());
        send_request(list_op(ACT_INS_FRONT, 32'hffff_ffff, 8'h00), pick_pause());
        send_request(list_op(ACT_APPEND, 32'h5555_5555, 8'haa), pick_pause());
        send_request(list_op(ACT_INS_FRONT, 32'haaaa_aaaa, 8'h55), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'hff), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd6), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd5), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd0), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd2), pick_pause());
        send_request(list_op(ACT_NONE, 32'hffff_ffff, 8'hff), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd0), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd1), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd0), pick_pause());
        send_request(list_op(ACT_DELETE, 32'h0, 8'd0), pick_pause());

        // first segment fills the list and runs into dropped inserts
        issued  = 0;
        mode    = MODE_FILL;
        seg_len = LIST_DEPTH + 8;
        while (issued < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                send_request(make_request(mode, sb.n_entries), calm ? 0 : pick_pause());
                issued++;
            end
            mode    = t_mode'($urandom_range(1, 3));
            seg_len = $urandom_range(10, 50);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver: calm and choppy stretches, plus one long hold-off to back up the block
    always @(posedge clk) begin
        if (hold_left > 1) begin
            hold_left--;
        end else if (hold_left == 1) begin
            hold_left = 0;
            out_stall <= 1'b0;
        end else if (!held_off && n_accepted >= HOLD_OFF_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 200);
                choppy       = ($urandom_range(0, 1) != 0);
            end
            stretch_left--;
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (choppy) begin
                stall_left = pick_pause();
                out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_bus);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
